>>> hdl/greedy_coflow_rate_allocator_top_assert.svh
// Assertion macros for the greedy coflow rate allocator.
// Included by the top level. No other dependencies.
`ifndef GREEDY_COFLOW_RATE_ALLOCATOR_TOP_ASSERT_SVH
`define GREEDY_COFLOW_RATE_ALLOCATOR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GCRA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GCRA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/gcra_pkg.sv
// Shared constants, codes and types of the greedy coflow rate allocator.
// Used by gcra_muldiv and the top level. No dependencies.
package gcra_pkg;

   localparam int MAX_FLOWS   = 32;
   localparam int NUM_PORTS   = 16;
   localparam int MAX_COFLOWS = 16;
   localparam int IDX_W       = $clog2(MAX_FLOWS);
   localparam int CNT_W       = IDX_W + 1;
   localparam int PORT_W      = 4;

   localparam logic [31:0] NS_PER_S = 32'd1000000000;

   localparam logic [1:0] CMD_LOAD = 2'd0;
   localparam logic [1:0] CMD_PORT = 2'd1;
   localparam logic [1:0] CMD_RUN  = 2'd2;

   localparam logic [1:0] KIND_FLOW   = 2'd0;
   localparam logic [1:0] KIND_COFLOW = 2'd1;
   localparam logic [1:0] KIND_EPOCH  = 2'd2;

   // Request to the shared multiply-divide unit: floor(x*k scaled / d).
   typedef struct packed {
      logic        start;
      logic        up;     // 1: scale product up by 2^16, 0: down by 2^16
      logic [63:0] x;
      logic [31:0] k;
      logic [31:0] d;
   } unit_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [62:0] q;
   } unit_rsp_type;

endpackage

>>> hdl/gcra_muldiv.sv
// Shared iterative multiply-then-divide unit: q = floor((x*k) * 2^(+-16) / d).
// Depends on gcra_pkg. Shift-add multiply, then restoring division.
module gcra_muldiv (
   input  logic                  clock,
   input  logic                  reset,
   input  gcra_pkg::unit_req_type req,
   output gcra_pkg::unit_rsp_type rsp
);

   localparam logic [1:0] U_IDLE = 2'd0;
   localparam logic [1:0] U_MUL  = 2'd1;
   localparam logic [1:0] U_LOAD = 2'd2;
   localparam logic [1:0] U_DIV  = 2'd3;

   logic [1:0]  phase_ff, phase_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        done_ff, done_in;
   logic        up_ff, up_in;
   logic [31:0] d_ff, d_in;
   logic [95:0] acc_ff, acc_in;
   logic [95:0] xs_ff, xs_in;
   logic [31:0] kr_ff, kr_in;
   logic [79:0] num_ff, num_in;
   logic [31:0] rem_ff, rem_in;
   logic [79:0] quot_ff, quot_in;
   logic [32:0] trial;
   logic        ge;

   // One multiply bit or one quotient bit per cycle.
   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      up_in    = up_ff;
      d_in     = d_ff;
      acc_in   = acc_ff;
      xs_in    = xs_ff;
      kr_in    = kr_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      trial    = {rem_ff, num_ff[79]};
      ge       = (trial >= {1'b0, d_ff});
      case (phase_ff)
         U_IDLE: begin
            if (req.start) begin
               acc_in   = '0;
               xs_in    = {32'd0, req.x};
               kr_in    = req.k;
               up_in    = req.up;
               d_in     = req.d;
               cnt_in   = '0;
               phase_in = U_MUL;
            end
         end
         U_MUL: begin
            if (kr_ff[0]) begin
               acc_in = acc_ff + xs_ff;
            end
            xs_in  = {xs_ff[94:0], 1'b0};
            kr_in  = {1'b0, kr_ff[31:1]};
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff == 7'd31) begin
               phase_in = U_LOAD;
            end
         end
         // A product of 2^64 or more scaled up saturates the dividend; the quotient
         // then still exceeds any 48-bit byte count.
         U_LOAD: begin
            if (up_ff) begin
               num_in = (acc_ff[95:64] != 32'd0) ? {80{1'b1}} : {acc_ff[63:0], 16'd0};
            end else begin
               num_in = acc_ff[95:16];
            end
            rem_in   = '0;
            quot_in  = '0;
            cnt_in   = '0;
            phase_in = U_DIV;
         end
         U_DIV: begin
            rem_in  = ge ? 32'(trial - {1'b0, d_ff}) : trial[31:0];
            quot_in = {quot_ff[78:0], ge};
            num_in  = {num_ff[78:0], 1'b0};
            cnt_in  = cnt_ff + 7'd1;
            if (cnt_ff == 7'd79) begin
               phase_in = U_IDLE;
               done_in  = 1'b1;
            end
         end
         default: phase_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= U_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      up_ff   <= up_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      xs_ff   <= xs_in;
      kr_ff   <= kr_in;
      num_ff  <= num_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign rsp.busy = (phase_ff != U_IDLE);
   assign rsp.done = done_ff;
   assign rsp.q    = quot_ff[62:0];

endmodule

>>> hdl/greedy_coflow_rate_allocator_top.sv
// Greedy coflow rate allocator top: load and port items are applied from the idle state.
// A run passes the head, coflow id and scan states for each coflow group, then walks the flows
// of each group that has bytes left to allocate, then walks all flows to drain; each allocated
// flow uses the shared unit in both walks (issue, multiply, load, divide, done).
// One item at a time; input is not ready while a run is in progress.
// Sync active-high reset clears count, flags and bandwidths; needs gcra_pkg, gcra_muldiv.
`include "greedy_coflow_rate_allocator_top_assert.svh"
module greedy_coflow_rate_allocator_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // coflow[3:0], sender_port[7:4], receiver_port[11:8], flow_size[59:12],
   // port_index[63:60], send_bandwidth[95:64], recv_bandwidth[127:96],
   // epoch_limit[190:128], current_time[253:191], zeros above
   input  logic [255:0] req_tdata,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // item_id[4:0], event_time[67:5], zeros above
   output logic [71:0]  rsp_tdata,
   // kind[1:0]
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);

   localparam int IW = gcra_pkg::IDX_W;
   localparam int CW = gcra_pkg::CNT_W;
   localparam int PW = gcra_pkg::PORT_W;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_HEAD   = 4'd1;
   localparam logic [3:0] S_CID    = 4'd2;
   localparam logic [3:0] S_ANY    = 4'd3;
   localparam logic [3:0] S_ALLOC  = 4'd4;
   localparam logic [3:0] S_FIN    = 4'd5;
   localparam logic [3:0] S_DRAIN  = 4'd6;
   localparam logic [3:0] S_DWAIT  = 4'd7;
   localparam logic [3:0] S_EPOCH  = 4'd8;

   // Input fields.
   logic [3:0]  in_cof, in_snd, in_rcv, in_port;
   logic [47:0] in_size;
   logic [31:0] in_sbw, in_rbw;
   logic [62:0] in_max, in_now;
   assign in_cof  = req_tdata[3:0];
   assign in_snd  = req_tdata[7:4];
   assign in_rcv  = req_tdata[11:8];
   assign in_size = req_tdata[59:12];
   assign in_port = req_tdata[63:60];
   assign in_sbw  = req_tdata[95:64];
   assign in_rbw  = req_tdata[127:96];
   assign in_max  = req_tdata[190:128];
   assign in_now  = req_tdata[253:191];

   // Flow table and port tables.
   logic [3:0]  fcof_ff [gcra_pkg::MAX_FLOWS];
   logic [PW-1:0] fsnd_ff [gcra_pkg::MAX_FLOWS];
   logic [PW-1:0] frcv_ff [gcra_pkg::MAX_FLOWS];
   logic [47:0] frem_ff [gcra_pkg::MAX_FLOWS];
   logic [31:0] frate_ff [gcra_pkg::MAX_FLOWS];
   logic [gcra_pkg::MAX_FLOWS-1:0] falloc_ff, frep_ff;
   logic [gcra_pkg::MAX_COFLOWS-1:0] crep_ff;
   logic [31:0] sfull_ff [gcra_pkg::NUM_PORTS];
   logic [31:0] rfull_ff [gcra_pkg::NUM_PORTS];
   logic [31:0] sspare_ff [gcra_pkg::NUM_PORTS];
   logic [31:0] rspare_ff [gcra_pkg::NUM_PORTS];

   // Sequencer registers.
   logic [3:0]  state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] g_ff, g_in, i_ff, i_in, end_ff, end_in;
   logic [3:0]  cid_ff, cid_in;
   logic        any_ff, any_in;
   logic [62:0] length_ff, length_in;
   logic [62:0] now_ff, now_in;

   // Output register.
   logic        ovalid_ff, ovalid_in;
   logic [1:0]  okind_ff;
   logic [4:0]  oid_ff;
   logic [62:0] otime_ff;
   logic        olast_ff;

   // Control pulses.
   logic        emit, wr_load, wr_port, set_frep, set_crep, alloc_wr, drain_wr;
   logic [1:0]  emit_kind;
   logic [4:0]  emit_id;
   logic [62:0] emit_time;
   logic        emit_last, out_free;

   // Current flow entry at the walk index.
   logic [IW-1:0] idx;
   logic [3:0]  cur_cof;
   logic [PW-1:0] cur_snd, cur_rcv;
   logic [47:0] cur_rem, new_rem;
   logic [31:0] cur_rate, sp_s, sp_r, min_rate;
   logic [62:0] sent;

   gcra_pkg::unit_req_type ureq;
   gcra_pkg::unit_rsp_type ursp;

   assign idx      = i_ff[IW-1:0];
   assign cur_cof  = fcof_ff[idx];
   assign cur_snd  = fsnd_ff[idx];
   assign cur_rcv  = frcv_ff[idx];
   assign cur_rem  = frem_ff[idx];
   assign cur_rate = frate_ff[idx];
   assign sp_s     = sspare_ff[cur_snd];
   assign sp_r     = rspare_ff[cur_rcv];
   assign min_rate = (sp_s < sp_r) ? sp_s : sp_r;
   assign sent     = ursp.q;
   assign new_rem  = (sent >= {15'd0, cur_rem}) ? 48'd0 : 48'(cur_rem - sent[47:0]);
   assign out_free = !ovalid_ff || rsp_tready;

   // Request to the shared unit: finish time while allocating, bytes sent while draining.
   always_comb begin
      ureq.start = 1'b0;
      ureq.up    = (state_ff == S_DRAIN);
      ureq.x     = (state_ff == S_DRAIN) ? {1'b0, length_ff} : {16'd0, cur_rem};
      ureq.k     = (state_ff == S_DRAIN) ? cur_rate : gcra_pkg::NS_PER_S;
      ureq.d     = (state_ff == S_DRAIN) ? gcra_pkg::NS_PER_S : min_rate;
      if (state_ff == S_ALLOC && i_ff < end_ff && cur_rem != '0
          && sp_s != '0 && sp_r != '0) begin
         ureq.start = 1'b1;
      end
      if (state_ff == S_DRAIN && i_ff < count_ff && falloc_ff[idx]) begin
         ureq.start = 1'b1;
      end
   end

   gcra_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (ureq),
      .rsp   (ursp)
   );

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      g_in      = g_ff;
      i_in      = i_ff;
      end_in    = end_ff;
      cid_in    = cid_ff;
      any_in    = any_ff;
      length_in = length_ff;
      now_in    = now_ff;
      emit      = 1'b0;
      emit_kind = gcra_pkg::KIND_FLOW;
      emit_id   = '0;
      emit_time = now_ff;
      emit_last = 1'b0;
      wr_load   = 1'b0;
      wr_port   = 1'b0;
      set_frep  = 1'b0;
      set_crep  = 1'b0;
      alloc_wr  = 1'b0;
      drain_wr  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  gcra_pkg::CMD_LOAD: begin
                     if (count_ff < CW'(gcra_pkg::MAX_FLOWS)) begin
                        wr_load  = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  gcra_pkg::CMD_PORT: wr_port = 1'b1;
                  gcra_pkg::CMD_RUN: begin
                     length_in = in_max;
                     now_in    = in_now;
                     g_in      = '0;
                     state_in  = S_HEAD;
                  end
                  default: ;
               endcase
            end
         end
         S_HEAD: begin
            i_in = g_ff;
            if (g_ff >= count_ff) begin
               i_in     = '0;
               state_in = S_DRAIN;
            end else begin
               state_in = S_CID;
            end
         end
         S_CID: begin
            cid_in   = cur_cof;
            any_in   = 1'b0;
            state_in = S_ANY;
         end
         // Find the end of the group and whether any flow has bytes left.
         S_ANY: begin
            if (i_ff < count_ff && cur_cof == cid_ff) begin
               any_in = any_ff | (cur_rem != '0);
               i_in   = i_ff + CW'(1);
            end else begin
               end_in = i_ff;
               if (any_ff) begin
                  i_in     = g_ff;
                  state_in = S_ALLOC;
               end else if (crep_ff[cid_ff]) begin
                  g_in     = i_ff;
                  state_in = S_HEAD;
               end else if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = gcra_pkg::KIND_COFLOW;
                  emit_id   = {1'b0, cid_ff};
                  set_crep  = 1'b1;
                  g_in      = i_ff;
                  state_in  = S_HEAD;
               end
            end
         end
         S_ALLOC: begin
            if (i_ff >= end_ff) begin
               g_in     = end_ff;
               state_in = S_HEAD;
            end else if (cur_rem == '0) begin
               if (frep_ff[idx]) begin
                  i_in = i_ff + CW'(1);
               end else if (out_free) begin
                  emit      = 1'b1;
                  emit_kind = gcra_pkg::KIND_FLOW;
                  emit_id   = 5'(idx);
                  set_frep  = 1'b1;
                  i_in      = i_ff + CW'(1);
               end
            end else if (sp_s != '0 && sp_r != '0) begin
               alloc_wr = 1'b1;
               state_in = S_FIN;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_FIN: begin
            if (ursp.done) begin
               if (ursp.q < length_ff) begin
                  length_in = ursp.q;
               end
               i_in     = i_ff + CW'(1);
               state_in = S_ALLOC;
            end
         end
         S_DRAIN: begin
            if (i_ff >= count_ff) begin
               state_in = S_EPOCH;
            end else if (falloc_ff[idx]) begin
               state_in = S_DWAIT;
            end else begin
               i_in = i_ff + CW'(1);
            end
         end
         S_DWAIT: begin
            if (ursp.done) begin
               drain_wr = 1'b1;
               i_in     = i_ff + CW'(1);
               state_in = S_DRAIN;
            end
         end
         S_EPOCH: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_kind = gcra_pkg::KIND_EPOCH;
               emit_id   = '0;
               emit_time = length_ff;
               emit_last = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      ovalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : ovalid_ff);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         ovalid_ff <= ovalid_in;
      end
      g_ff      <= g_in;
      i_ff      <= i_in;
      end_ff    <= end_in;
      cid_ff    <= cid_in;
      any_ff    <= any_in;
      length_ff <= length_in;
      now_ff    <= now_in;
      if (emit) begin
         okind_ff <= emit_kind;
         oid_ff   <= emit_id;
         otime_ff <= emit_time;
         olast_ff <= emit_last;
      end
   end

   // Flow table payload.
   always_ff @(posedge clock) begin
      if (wr_load) begin
         fcof_ff[count_ff[IW-1:0]] <= in_cof;
         fsnd_ff[count_ff[IW-1:0]] <= in_snd;
         frcv_ff[count_ff[IW-1:0]] <= in_rcv;
         frem_ff[count_ff[IW-1:0]] <= in_size;
      end
      if (alloc_wr) begin
         frate_ff[idx] <= min_rate;
      end
      if (drain_wr) begin
         frem_ff[idx] <= new_rem;
      end
   end

   // Flow and coflow flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         falloc_ff <= '0;
         frep_ff   <= '0;
         crep_ff   <= '0;
      end else begin
         if (wr_load) begin
            falloc_ff[count_ff[IW-1:0]] <= 1'b0;
            frep_ff[count_ff[IW-1:0]]   <= 1'b0;
         end
         if (alloc_wr) begin
            falloc_ff[idx] <= 1'b1;
         end
         if (drain_wr) begin
            falloc_ff[idx] <= 1'b0;
         end
         if (set_frep) begin
            frep_ff[idx] <= 1'b1;
         end
         if (set_crep) begin
            crep_ff[cid_ff] <= 1'b1;
         end
      end
   end

   // Port bandwidths: spare drops on allocation and returns to full on drain.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < gcra_pkg::NUM_PORTS; p++) begin
            sfull_ff[p]  <= '0;
            rfull_ff[p]  <= '0;
            sspare_ff[p] <= '0;
            rspare_ff[p] <= '0;
         end
      end else begin
         if (wr_port) begin
            sfull_ff[in_port]  <= in_sbw;
            rfull_ff[in_port]  <= in_rbw;
            sspare_ff[in_port] <= in_sbw;
            rspare_ff[in_port] <= in_rbw;
         end
         if (alloc_wr) begin
            sspare_ff[cur_snd] <= sp_s - min_rate;
            rspare_ff[cur_rcv] <= sp_r - min_rate;
         end
         if (drain_wr) begin
            sspare_ff[cur_snd] <= sfull_ff[cur_snd];
            rspare_ff[cur_rcv] <= rfull_ff[cur_rcv];
         end
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {4'd0, otime_ff, oid_ff};
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;

   // The unit is idle whenever a new item may enter.
   `GCRA_ASSERT_SAME(a_unit_idle, clock, reset, req_tready, !ursp.busy, "unit busy in idle")
   // The unit is only started when idle.
   `GCRA_ASSERT_SAME(a_no_restart, clock, reset, ureq.start, !ursp.busy, "unit restarted")
   // The flow count never exceeds the table.
   `GCRA_ASSERT_SAME(a_count, clock, reset, 1'b1,
      count_ff <= CW'(gcra_pkg::MAX_FLOWS), "flow count overflow")
   // The epoch length result is the last one of a run and carries tlast.
   `GCRA_ASSERT_SAME(a_last, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_tuser == gcra_pkg::KIND_EPOCH), "tlast mismatch")

endmodule

>>> tb/sv/gcra_scoreboard.sv
`timescale 1ns / 100ps
// Prediction and checking for the greedy coflow rate allocator: watches both stream channels.
// Keeps its own copy of the flow table and the port bandwidths. Depends on gcra_pkg.
module gcra_scoreboard (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [255:0] req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [71:0]  rsp_tdata,
   input  logic [1:0]   rsp_tuser,
   input  logic         rsp_tlast,
   output int           fail_count,
   output int           pending
);

   localparam logic [63:0] NS = 64'd1000000000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [4:0]  id;
      logic [62:0] stamp;
      logic        last;
   } event_type;

   // Shadow flow table and port bandwidths.
   logic [3:0]  fl_coflow [gcra_pkg::MAX_FLOWS];
   logic [3:0]  fl_sender [gcra_pkg::MAX_FLOWS];
   logic [3:0]  fl_recv [gcra_pkg::MAX_FLOWS];
   logic [47:0] fl_bytes [gcra_pkg::MAX_FLOWS];
   logic [31:0] fl_rate [gcra_pkg::MAX_FLOWS];
   logic        fl_alloc [gcra_pkg::MAX_FLOWS];
   logic        fl_done [gcra_pkg::MAX_FLOWS];
   logic        cf_done [gcra_pkg::MAX_COFLOWS];
   int          n_flows;
   logic [31:0] tx_full [gcra_pkg::NUM_PORTS];
   logic [31:0] rx_full [gcra_pkg::NUM_PORTS];
   logic [31:0] tx_spare [gcra_pkg::NUM_PORTS];
   logic [31:0] rx_spare [gcra_pkg::NUM_PORTS];

   event_type due_events[$];

   // floor(x * k / d) with long division of the remainder, bit by bit over k.
   function automatic logic [63:0] scaled_quotient(logic [63:0] x, logic [63:0] k,
                                                   logic [63:0] d);
      logic [63:0] q, r, acc, rem;
      q = x / d;
      r = x % d;
      acc = 0;
      rem = 0;
      for (int b = 31; b >= 0; b--) begin
         acc = acc << 1;
         rem = rem << 1;
         if (k[b]) rem = rem + r;
         while (rem >= d) begin
            rem = rem - d;
            acc = acc + 1;
         end
      end
      return q * k + acc;
   endfunction

   // Bytes left after sending at rate for t ns, saturating at zero.
   function automatic logic [47:0] bytes_left(logic [47:0] remaining, logic [31:0] rate,
                                              logic [63:0] t);
      logic [63:0] tq, tr, whole, part, sent;
      if (rate == 0) return remaining;
      tq = t / NS;
      tr = t % NS;
      if (tq >= 64'h1_0000_0000) return 0;
      whole = rate * tq;
      if (whole >= 64'h1_0000_0000) return 0;
      part = scaled_quotient(rate * tr, 64'd65536, NS);
      sent = (whole << 16) + part;
      return (sent >= remaining) ? 48'd0 : remaining - sent[47:0];
   endfunction

   // One scheduling epoch: completions in walk order, then the epoch length.
   task automatic predict_epoch(logic [62:0] max_t, logic [62:0] now);
      logic [63:0] length, fin;
      logic [31:0] rate;
      int g, stop;
      logic busy;
      logic [3:0] cid, s, r;
      length = {1'b0, max_t};
      g = 0;
      while (g < n_flows) begin
         cid = fl_coflow[g];
         stop = g + 1;
         while (stop < n_flows && fl_coflow[stop] == cid) stop++;
         busy = 0;
         for (int i = g; i < stop; i++) if (fl_bytes[i] != 0) busy = 1;
         if (busy) begin
            for (int j = g; j < stop; j++) begin
               s = fl_sender[j];
               r = fl_recv[j];
               if (fl_bytes[j] == 0) begin
                  if (!fl_done[j]) begin
                     fl_done[j] = 1;
                     due_events.insert(due_events.size(),
                                       '{gcra_pkg::KIND_FLOW, j[4:0], now, 1'b0});
                  end
               end else if (tx_spare[s] != 0 && rx_spare[r] != 0) begin
                  rate = (tx_spare[s] < rx_spare[r]) ? tx_spare[s] : rx_spare[r];
                  fl_rate[j] = rate;
                  fl_alloc[j] = 1;
                  tx_spare[s] -= rate;
                  rx_spare[r] -= rate;
                  fin = scaled_quotient(fl_bytes[j], NS, {16'd0, rate, 16'd0});
                  if (fin < length) length = fin;
               end
            end
         end else if (!cf_done[cid]) begin
            cf_done[cid] = 1;
            due_events.insert(due_events.size(),
                              '{gcra_pkg::KIND_COFLOW, {1'b0, cid}, now, 1'b0});
         end
         g = stop;
      end
      // Drain the allocated flows and give the ports their bandwidth back.
      for (int i = 0; i < n_flows; i++) begin
         if (fl_alloc[i]) begin
            fl_bytes[i] = bytes_left(fl_bytes[i], fl_rate[i], length);
            tx_spare[fl_sender[i]] = tx_full[fl_sender[i]];
            rx_spare[fl_recv[i]] = rx_full[fl_recv[i]];
            fl_alloc[i] = 0;
         end
      end
      due_events.insert(due_events.size(),
                        '{gcra_pkg::KIND_EPOCH, 5'd0, length[62:0], 1'b1});
   endtask

   // Sample both channels at the rising edge; requests first.
   always @(posedge clock) begin
      event_type got, want;
      if (reset) begin
         n_flows = 0;
         fail_count = 0;
         due_events.delete();
         for (int i = 0; i < gcra_pkg::MAX_FLOWS; i++) begin
            fl_rate[i] = 0;
            fl_alloc[i] = 0;
            fl_done[i] = 0;
         end
         for (int i = 0; i < gcra_pkg::MAX_COFLOWS; i++) cf_done[i] = 0;
         for (int p = 0; p < gcra_pkg::NUM_PORTS; p++) begin
            tx_full[p] = 0;
            rx_full[p] = 0;
            tx_spare[p] = 0;
            rx_spare[p] = 0;
         end
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               gcra_pkg::CMD_LOAD: if (n_flows < gcra_pkg::MAX_FLOWS) begin
                  fl_coflow[n_flows] = req_tdata[3:0];
                  fl_sender[n_flows] = req_tdata[7:4];
                  fl_recv[n_flows] = req_tdata[11:8];
                  fl_bytes[n_flows] = req_tdata[59:12];
                  fl_rate[n_flows] = 0;
                  fl_alloc[n_flows] = 0;
                  fl_done[n_flows] = 0;
                  n_flows++;
               end
               gcra_pkg::CMD_PORT: begin
                  tx_full[req_tdata[63:60]] = req_tdata[95:64];
                  rx_full[req_tdata[63:60]] = req_tdata[127:96];
                  tx_spare[req_tdata[63:60]] = req_tdata[95:64];
                  rx_spare[req_tdata[63:60]] = req_tdata[127:96];
               end
               gcra_pkg::CMD_RUN: predict_epoch(req_tdata[190:128], req_tdata[253:191]);
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser, rsp_tdata[4:0], rsp_tdata[67:5], rsp_tlast};
            if (due_events.size() == 0) begin
               $display("%0t: unexpected result kind=%0d id=%0d time=%0d last=%0b", $time,
                        got.kind, got.id, got.stamp, got.last);
               fail_count++;
            end else begin
               want = due_events.pop_front();
               if (got !== want) begin
                  $display("%0t: expected kind=%0d id=%0d time=%0d last=%0b", $time,
                           want.kind, want.id, want.stamp, want.last);
                  $display("%0t:   actual kind=%0d id=%0d time=%0d last=%0b", $time,
                           got.kind, got.id, got.stamp, got.last);
                  fail_count++;
               end
            end
         end
      end
      pending = due_events.size();
   end

endmodule

>>> tb/sv/tb_greedy_coflow_rate_allocator_top.sv
`timescale 1ns / 100ps
// Testbench top for the greedy coflow rate allocator: clock, reset, stimulus and verdict.
// Depends on gcra_pkg, greedy_coflow_rate_allocator_top and gcra_scoreboard.
module tb_greedy_coflow_rate_allocator_top;

   localparam int IDLE_LIMIT = 60000;
   localparam int N_RANDOM   = 280;
   localparam logic [62:0] T_MAX = {63{1'b1}};
   // Command code that the block ignores.
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [255:0] req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [71:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   int           fail_count;
   int           pending;
   bit           hold_off_req;

   greedy_coflow_rate_allocator_top dut (.*);

   gcra_scoreboard checker_i (.*);

   // Clock with a 4 ns period.
   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Random full-width values.
   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   function automatic logic [47:0] rand_size();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick < 3) return 48'(rand64());
      return 48'($urandom() & 32'hFF_FFFF) << $urandom_range(0, 24);
   endfunction

   function automatic logic [31:0] rand_bw();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick < 3) return $urandom();
      return $urandom_range(1, 1 << 20);
   endfunction

   function automatic logic [62:0] rand_span();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return 0;
      if (pick < 3) return 63'(rand64());
      return 63'(rand64() % 64'd20000000000);
   endfunction

   // Offer one item, after an optional gap, and wait until it is accepted.
   task automatic send(logic [1:0] cmd, logic [255:0] data);
      int gap;
      gap = $urandom_range(0, 9);
      gap = (gap < 5) ? 0 : (gap < 9) ? $urandom_range(1, 3) : $urandom_range(10, 60);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tuser <= cmd;
      req_tdata <= data;
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_flow(logic [3:0] cid, logic [3:0] s, logic [3:0] r, logic [47:0] sz);
      logic [255:0] d;
      d = {64'd0, rand64(), rand64(), rand64()};
      d[59:0] = {sz, r, s, cid};
      send(gcra_pkg::CMD_LOAD, d);
   endtask

   task automatic set_port(logic [3:0] p, logic [31:0] tx, logic [31:0] rx);
      logic [255:0] d;
      d = '0;
      d[11:0] = 12'($urandom());
      d[127:60] = {rx, tx, p};
      send(gcra_pkg::CMD_PORT, d);
   endtask

   task automatic run_epoch(logic [62:0] max_t, logic [62:0] now);
      logic [255:0] d;
      d = '0;
      d[59:0] = 60'(rand64());
      d[253:128] = {now, max_t};
      send(gcra_pkg::CMD_RUN, d);
   endtask

   // Receiver: mostly ready, random stalls, and one long hold-off on request.
   initial begin
      int stall;
      bit hold_seen;
      stall = 0;
      hold_seen = 0;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off_req && !hold_seen) begin
            hold_seen = 1;
            stall = 4000;
         end
         if (stall > 0) begin
            stall--;
            rsp_tready <= 0;
         end else if ($urandom_range(0, 11) == 0) begin
            stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4);
            rsp_tready <= 0;
         end else begin
            rsp_tready <= 1;
         end
      end
   end

   // Watchdog on cycles in which neither channel moves an item.
   initial begin
      int idle;
      idle = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle = 0;
         else idle++;
         if (idle >= IDLE_LIMIT) begin
            $display("greedy_coflow_rate_allocator_top regression: fail");
            $finish;
         end
      end
   end

   // Stimulus and verdict.
   initial begin
      int pick;
      hold_off_req = 0;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = gcra_pkg::CMD_LOAD;
      reset = 1;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty table, unknown command, bandwidth extremes, special flows.
      run_epoch(T_MAX, 0);
      send(CMD_UNUSED, {4{rand64()}});
      set_port(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      set_port(4'd15, 32'd1, 32'd1000);
      set_port(4'd1, 32'd0, 32'd5000);
      set_port(4'd2, 32'd123456, 32'd654321);
      load_flow(4'd0, 4'd0, 4'd15, 48'hFFFF_FFFF_FFFF);
      load_flow(4'd0, 4'd15, 4'd0, 48'd0);
      load_flow(4'd1, 4'd1, 4'd2, 48'd10 << 16);
      load_flow(4'd15, 4'd2, 4'd2, 48'd0);
      load_flow(4'd0, 4'd2, 4'd15, 48'd1);
      run_epoch(0, T_MAX);
      run_epoch(T_MAX, 63'd12345);
      run_epoch(63'd1000000, 63'd77);
      set_port(4'd3, 32'd1 << 20, 32'd1 << 31);
      load_flow(4'd15, 4'd3, 4'd3, 48'd5 << 16);
      load_flow(4'd2, 4'd3, 4'd0, 48'd3 << 16);
      run_epoch(63'd5000000000, 63'd99);
      run_epoch(T_MAX, 63'd100);
      set_port(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      run_epoch(T_MAX, 63'd101);

      // Random: a mix of loads, port changes, epochs and unknown commands.
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 100) hold_off_req = 1;
         if (i == 200) while (pending != 0) @(negedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 35)
            load_flow(4'($urandom()), 4'($urandom()), 4'($urandom()), rand_size());
         else if (pick < 65)
            set_port(4'($urandom()), rand_bw(), rand_bw());
         else if (pick < 96)
            run_epoch(rand_span(), 63'(rand64()));
         else
            send(CMD_UNUSED, {4{rand64()}});
      end
      req_tvalid <= 0;

      // Drain the remaining results, then let the block settle.
      while (pending != 0) @(negedge clock);
      repeat (400) @(posedge clock);
      if (fail_count == 0)
         $display("greedy_coflow_rate_allocator_top regression: pass");
      else
         $display("greedy_coflow_rate_allocator_top regression: fail");
      $finish;
   end

endmodule
